// ===== rtl/pcr_pkg.sv =====
// Shared types and constants of the pairwise cutoff relaxation core.
// Holds the controller/datapath command and status structs, command codes,
// register indexes and stream field layout. Depends on nothing.
package pcr_pkg;

	// stream payload layout
	localparam int IDX_W     = 9;
	localparam int POS_W     = 32;
	localparam int TDATA_W   = 112;
	localparam int IDX_LSB   = 0;
	localparam int X_LSB     = 9;
	localparam int Y_LSB     = 41;
	localparam int Z_LSB     = 73;
	localparam int FIX_BIT   = 105;
	localparam int PRES_BIT  = 106;
	localparam int TDATA_PAD = 5;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_STEP = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_AW-1:0] REG_VCOUNT = 3'd0;
	localparam logic [CFG_AW-1:0] REG_DIMS   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_MAXR   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_MINR   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_DT     = 3'd4;

	localparam int VCOUNT_W = 10;
	localparam int DIMS_W   = 2;
	localparam logic [DIMS_W-1:0] DIMS_RST = 2'd3;
	localparam logic [31:0]       DT_RST   = 32'd429497;

	// arithmetic widths
	localparam int VEL_W    = 32;
	localparam int RAD_W    = 64;
	localparam int ROOT_W   = 32;
	localparam int TERM_W   = 49;
	localparam int TERM_SH  = 16;
	localparam logic [4:0] ROOT_LAST = 5'd31;

	// controller to datapath commands
	typedef struct packed {
		logic acc;      // input transaction taken, latch index
		logic load;     // write the loaded vertex
		logic rd_issue; // read the requested vertex
		logic out_read; // put the read vertex in the output register
		logic out_done; // put the step result in the output register
		logic i_clr;
		logic i_inc;
		logic clr_wr;   // clear velocity slot i
		logic i_rd;
		logic i_ld;
		logic j_rd;
		logic j_ld;
		logic j_inc;
		logic sq;
		logic acc_sum;
		logic sqrt_go;
		logic rad_ld;
		logic t1;
		logic t2;
		logic t3;
		logic t4;
		logic t5;
		logic vj_wr;
		logic upd_wr;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic i_end;
		logic j_end;
		logic k_end;
		logic pres;
		logic fix_i;
		logic skip;
		logic sqrt_done;
		logic in_range;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/pairwise_cutoff_relaxation_core.sv =====
// Top level of the pairwise cutoff relaxation core: stream ports, config port,
// controller and datapath. Depends on pcr_pkg, pcr_ctrl and pcr_datapath.
//
// A load transaction writes one vertex in the cycle it is accepted; a read
// transaction reads its vertex from RAM and then places it in the output
// register once that register is free. A step transaction first zeroes
// the velocity of the n active slots, then walks every pair i<j of present
// vertices: for each it sums the squared distance axis by axis, takes the
// root in the one-bit-per-cycle square root unit and, when in range, forms
// a force term per axis from 32x32 multiplies. Pairs with an absent vertex
// are skipped after its read. Only one transaction is worked on at a time;
// a finished result waits in the output register while loads are still taken.
module pairwise_cutoff_relaxation_core #(
	parameter int MAX_VERTICES = 512,
	parameter int COORD_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// vertex_index, pos_x, pos_y, pos_z, is_fixed, is_present, zero pad
	input  logic [pcr_pkg::TDATA_W-1:0]   s_tdata,
	// command
	input  logic [1:0]                    s_tuser,
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_index, out_x, out_y, out_z, out_fixed, out_present, zero pad
	output logic [pcr_pkg::TDATA_W-1:0]   m_tdata,
	// step_done
	output logic                          m_tuser,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [pcr_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [pcr_pkg::CFG_DW-1:0]    cfg_wdata
);
	import pcr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencing
	pcr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_cmd(s_tuser),
		.s_tready(s_tready), .stat(stat), .cmd(cmd)
	);

	// storage and arithmetic
	pcr_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .s_tdata(s_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

// ===== rtl/pcr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for vertex and velocity storage. No dependencies.
module pcr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pcr_isqrt.sv =====
// Iterative integer square root, one result bit per cycle over a 64-bit radicand.
// Uses widths from pcr_pkg.
module pcr_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pcr_pkg::RAD_W-1:0] radicand,
	output logic [pcr_pkg::ROOT_W-1:0] root,
	output logic                      done
);
	import pcr_pkg::*;

	logic [RAD_W-1:0]  x_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [ROOT_W+1:0] rem_n;
	logic [ROOT_W+1:0] trial;
	logic              ge;

	// one restoring step
	always_comb begin
		rem_n = {rem_q[ROOT_W-1:0], x_q[RAD_W-1 -: 2]};
		trial = {root_q, 2'b01};
		ge    = rem_n >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == ROOT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? rem_n - trial : rem_n;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ===== rtl/pcr_datapath.sv =====
// Datapath of the relaxation core: config registers, vertex and velocity RAMs,
// loop counters, pair arithmetic and the output register.
// Depends on pcr_pkg, pcr_ram and pcr_isqrt.
module pcr_datapath #(
	parameter int MAX_VERTICES = 512,
	parameter int COORD_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcr_pkg::cmd_t                 cmd,
	output pcr_pkg::stat_t                stat,
	input  logic [pcr_pkg::TDATA_W-1:0]   s_tdata,
	input  logic                          cfg_we,
	input  logic [pcr_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [pcr_pkg::CFG_DW-1:0]    cfg_wdata,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [pcr_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tuser
);
	import pcr_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int AW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int VTW = 3 * CB + 2;
	localparam int VLW = 3 * VEL_W;
	localparam int SW  = 50;
	localparam int VW  = 51;
	localparam int DW  = CB + 1;
	localparam logic signed [SW-1:0] PMAX = $signed((SW'(1) << (CB - 1)) - SW'(1));
	localparam logic signed [SW-1:0] PMIN = ~PMAX;
	localparam logic signed [VW-1:0] VMAX = $signed((VW'(1) << (VEL_W - 1)) - VW'(1));
	localparam logic signed [VW-1:0] VMIN = ~VMAX;

	function automatic logic signed [CB-1:0] sat_pos(input logic signed [SW-1:0] v);
		logic signed [CB-1:0] r;
		if (v > PMAX) r = PMAX[CB-1:0];
		else if (v < PMIN) r = PMIN[CB-1:0];
		else r = v[CB-1:0];
		return r;
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VW-1:0] v);
		logic signed [VEL_W-1:0] r;
		if (v > VMAX) r = VMAX[VEL_W-1:0];
		else if (v < VMIN) r = VMIN[VEL_W-1:0];
		else r = v[VEL_W-1:0];
		return r;
	endfunction

	// input fields
	logic [IDX_W-1:0]        in_idx;
	logic signed [POS_W-1:0] in_pos [3];
	logic                    in_fix;
	logic                    in_pres;
	logic                    ld_ok;

	assign in_idx    = s_tdata[IDX_LSB +: IDX_W];
	assign in_pos[0] = s_tdata[X_LSB +: POS_W];
	assign in_pos[1] = s_tdata[Y_LSB +: POS_W];
	assign in_pos[2] = s_tdata[Z_LSB +: POS_W];
	assign in_fix    = s_tdata[FIX_BIT];
	assign in_pres   = s_tdata[PRES_BIT];
	assign ld_ok     = 32'(in_idx) < MAX_VERTICES;

	// configuration registers
	logic [VCOUNT_W-1:0] vcount_q;
	logic [DIMS_W-1:0]   dims_q;
	logic [31:0]         maxr_q;
	logic [31:0]         minr_q;
	logic [31:0]         dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			dims_q   <= DIMS_RST;
			maxr_q   <= '0;
			minr_q   <= '0;
			dt_q     <= DT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_VCOUNT: vcount_q <= cfg_wdata[VCOUNT_W-1:0];
				REG_DIMS:   dims_q   <= cfg_wdata[DIMS_W-1:0];
				REG_MAXR:   maxr_q   <= cfg_wdata;
				REG_MINR:   minr_q   <= cfg_wdata;
				REG_DT:     dt_q     <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	logic [CW-1:0] n_eff;
	assign n_eff = (32'(vcount_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_q);

	// loop counters
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [1:0]    k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_inc) i_q <= i_q + CW'(1);
			if (cmd.i_ld) j_q <= i_q + CW'(1);
			else if (cmd.j_inc) j_q <= j_q + CW'(1);
			if (cmd.j_ld || cmd.rad_ld) k_q <= '0;
			else if (cmd.acc_sum || cmd.t5) k_q <= k_q + 2'd1;
		end
	end

	// request latch for reads
	logic [IDX_W-1:0] idx_q;
	logic             rd_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			idx_q   <= in_idx;
			rd_ok_q <= ld_ok;
		end
	end

	// vertex and velocity storage
	logic             v_we, v_re;
	logic [AW-1:0]    v_waddr, v_raddr;
	logic [VTW-1:0]   v_wdata, v_rd;
	logic             w_we, w_re;
	logic [AW-1:0]    w_waddr, w_raddr;
	logic [VLW-1:0]   w_wdata, w_rd;

	logic signed [CB-1:0]    pi_q [3];
	logic signed [CB-1:0]    pj_q [3];
	logic signed [VEL_W-1:0] vi_q [3];
	logic signed [VEL_W-1:0] vj_q [3];
	logic                    fi_q;
	logic signed [CB-1:0]    upd_pos [3];
	logic signed [CB-1:0]    ld_pos [3];

	// saturated load and update positions
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ld_pos[a]  = sat_pos(SW'(in_pos[a]));
			upd_pos[a] = (a < 32'(dims_q)) ? sat_pos(SW'(pi_q[a]) + SW'(vi_q[a])) : pi_q[a];
		end
	end

	assign v_we    = (cmd.load && ld_ok) || cmd.upd_wr;
	assign v_waddr = cmd.upd_wr ? i_q[AW-1:0] : AW'(in_idx);
	assign v_wdata = cmd.upd_wr ? {1'b1, fi_q, upd_pos[2], upd_pos[1], upd_pos[0]}
	                            : {in_pres, in_fix, ld_pos[2], ld_pos[1], ld_pos[0]};
	assign v_re    = cmd.rd_issue || cmd.i_rd || cmd.j_rd;
	assign v_raddr = cmd.rd_issue ? AW'(idx_q) : (cmd.i_rd ? i_q[AW-1:0] : j_q[AW-1:0]);

	assign w_we    = cmd.clr_wr || cmd.vj_wr;
	assign w_waddr = cmd.vj_wr ? j_q[AW-1:0] : i_q[AW-1:0];
	assign w_wdata = cmd.vj_wr ? {vj_q[2], vj_q[1], vj_q[0]} : '0;
	assign w_re    = cmd.i_rd || cmd.j_rd;
	assign w_raddr = cmd.i_rd ? i_q[AW-1:0] : j_q[AW-1:0];

	pcr_ram #(.WIDTH(VTW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.re(v_re), .raddr(v_raddr), .rdata(v_rd)
	);

	pcr_ram #(.WIDTH(VLW), .DEPTH(MAX_VERTICES)) u_vel_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.re(w_re), .raddr(w_raddr), .rdata(w_rd)
	);

	// per-axis difference of the current pair
	logic signed [DW-1:0] d;
	logic [DW-1:0]        mag;
	logic [63:0]          mag64;
	logic [31:0]          mag32;
	logic                 oor;

	always_comb begin
		d     = DW'(pi_q[k_q]) - DW'(pj_q[k_q]);
		mag   = d[DW-1] ? DW'(-d) : DW'(d);
		mag64 = 64'(mag);
		mag32 = mag64[31:0];
		oor   = |mag64[63:32];
	end

	// pair arithmetic registers
	logic [63:0]         sq_q;
	logic [RAD_W-1:0]    sum_q;
	logic                skip_q;
	logic [ROOT_W-1:0]   root;
	logic                sqrt_done;
	logic [31:0]         emag_q;
	logic                eneg_q;
	logic                dneg_q;
	logic [63:0]         p_q;
	logic [63:0]         m_q;
	logic [31:0]         lo_q;
	logic [TERM_W-1:0]   t_q;

	logic [RAD_W:0]      sum_n;
	logic [32:0]         e;
	logic [32:0]         e_neg;
	logic [64:0]         tsum;
	logic                neg;
	logic signed [VW-1:0] tv;
	logic signed [VW-1:0] vi_nx;
	logic signed [VW-1:0] vj_nx;

	always_comb begin
		sum_n = 65'(sum_q) + 65'(sq_q);
		e     = 33'(root) - 33'(minr_q);
		e_neg = -e;
		tsum  = 65'(m_q) + 65'(lo_q);
		neg   = dneg_q ^ eneg_q;
		tv    = $signed(VW'(t_q));
		vi_nx = neg ? VW'(vi_q[k_q]) + tv : VW'(vi_q[k_q]) - tv;
		vj_nx = neg ? VW'(vj_q[k_q]) - tv : VW'(vj_q[k_q]) + tv;
	end

	pcr_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_go), .radicand(sum_q),
		.root(root), .done(sqrt_done)
	);

	// vertex latches and pair sequence
	always_ff @(posedge clk) begin
		if (cmd.i_ld) begin
			for (int a = 0; a < 3; a++) begin
				pi_q[a] <= v_rd[a*CB +: CB];
				vi_q[a] <= w_rd[a*VEL_W +: VEL_W];
			end
			fi_q <= v_rd[3*CB];
		end
		if (cmd.j_ld) begin
			for (int a = 0; a < 3; a++) begin
				pj_q[a] <= v_rd[a*CB +: CB];
				vj_q[a] <= w_rd[a*VEL_W +: VEL_W];
			end
			sum_q  <= '0;
			skip_q <= 1'b0;
		end
		if (cmd.sq) begin
			sq_q   <= mag32 * mag32;
			skip_q <= skip_q | oor;
		end
		if (cmd.acc_sum) begin
			sum_q  <= sum_n[RAD_W-1:0];
			skip_q <= skip_q | sum_n[RAD_W];
		end
		if (cmd.rad_ld) begin
			eneg_q <= e[32];
			emag_q <= e[32] ? e_neg[31:0] : e[31:0];
		end
		if (cmd.t1) begin
			p_q    <= mag32 * emag_q;
			dneg_q <= d[DW-1];
		end
		if (cmd.t2) begin
			m_q <= p_q[31:0] * dt_q;
		end
		if (cmd.t3) begin
			lo_q <= m_q[63:32];
			m_q  <= p_q[63:32] * dt_q;
		end
		if (cmd.t4) begin
			t_q <= tsum[64:TERM_SH];
		end
		if (cmd.t5) begin
			vi_q[k_q] <= sat_vel(vi_nx);
			vj_q[k_q] <= sat_vel(vj_nx);
		end
	end

	// output register
	logic             m_tvalid_q;
	logic [IDX_W-1:0] o_idx_q;
	logic [POS_W-1:0] o_pos_q [3];
	logic             o_fix_q;
	logic             o_pres_q;
	logic             o_done_q;
	logic [63:0]      rd_pos [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rd_pos[a] = 64'(v_rd[a*CB +: CB]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_read || cmd.out_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_read) begin
			o_idx_q  <= idx_q;
			for (int a = 0; a < 3; a++) begin
				o_pos_q[a] <= rd_ok_q ? rd_pos[a][31:0] : '0;
			end
			o_fix_q  <= rd_ok_q & v_rd[3*CB];
			o_pres_q <= rd_ok_q & v_rd[3*CB+1];
			o_done_q <= 1'b0;
		end else if (cmd.out_done) begin
			o_idx_q  <= '0;
			for (int a = 0; a < 3; a++) begin
				o_pos_q[a] <= '0;
			end
			o_fix_q  <= 1'b0;
			o_pres_q <= 1'b0;
			o_done_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{TDATA_PAD{1'b0}}, o_pres_q, o_fix_q,
	                   o_pos_q[2], o_pos_q[1], o_pos_q[0], o_idx_q};
	assign m_tuser  = o_done_q;

	// status to the controller
	always_comb begin
		stat.i_end     = i_q == n_eff;
		stat.j_end     = j_q == n_eff;
		stat.k_end     = k_q == dims_q;
		stat.pres      = v_rd[3*CB+1];
		stat.fix_i     = fi_q;
		stat.skip      = skip_q;
		stat.sqrt_done = sqrt_done;
		stat.in_range  = root < maxr_q;
		stat.out_free  = !m_tvalid_q || m_tready;
	end

endmodule

// ===== rtl/pcr_ctrl.sv =====
// Controller state machine of the relaxation core: sequences load, read and
// the step loops over vertices, pairs and axes. Depends on pcr_pkg.
module pcr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic [1:0]     s_cmd,
	output logic           s_tready,
	input  pcr_pkg::stat_t stat,
	output pcr_pkg::cmd_t  cmd
);
	import pcr_pkg::*;

	typedef enum logic [19:0] {
		ST_IDLE = 20'h00001,
		ST_RD   = 20'h00002,
		ST_RDO  = 20'h00004,
		ST_CLR  = 20'h00008,
		ST_IRD  = 20'h00010,
		ST_ILD  = 20'h00020,
		ST_JRD  = 20'h00040,
		ST_JLD  = 20'h00080,
		ST_SQ   = 20'h00100,
		ST_ACC  = 20'h00200,
		ST_CHK  = 20'h00400,
		ST_SQRT = 20'h00800,
		ST_RAD  = 20'h01000,
		ST_T1   = 20'h02000,
		ST_T2   = 20'h04000,
		ST_T3   = 20'h08000,
		ST_T4   = 20'h10000,
		ST_T5   = 20'h20000,
		ST_UPD  = 20'h40000,
		ST_DONE = 20'h80000
	} state_t;

	state_t state_q, state_n;
	logic   accept;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.acc = 1'b1;
					case (s_cmd)
						CMD_LOAD: cmd.load = 1'b1;
						CMD_STEP: begin
							cmd.i_clr = 1'b1;
							state_n   = ST_CLR;
						end
						CMD_READ: state_n = ST_RD;
						default:  ;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_n      = ST_RDO;
			end
			ST_RDO: begin
				if (stat.out_free) begin
					cmd.out_read = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			// zero the velocity slots taking part
			ST_CLR: begin
				if (stat.i_end) begin
					cmd.i_clr = 1'b1;
					state_n   = ST_IRD;
				end else begin
					cmd.clr_wr = 1'b1;
					cmd.i_inc  = 1'b1;
				end
			end
			ST_IRD: begin
				if (stat.i_end) begin
					state_n = ST_DONE;
				end else begin
					cmd.i_rd = 1'b1;
					state_n  = ST_ILD;
				end
			end
			ST_ILD: begin
				cmd.i_ld = 1'b1;
				if (stat.pres) begin
					state_n = ST_JRD;
				end else begin
					cmd.i_inc = 1'b1;
					state_n   = ST_IRD;
				end
			end
			ST_JRD: begin
				if (stat.j_end) begin
					state_n = ST_UPD;
				end else begin
					cmd.j_rd = 1'b1;
					state_n  = ST_JLD;
				end
			end
			ST_JLD: begin
				cmd.j_ld = 1'b1;
				if (stat.pres) begin
					state_n = ST_SQ;
				end else begin
					cmd.j_inc = 1'b1;
					state_n   = ST_JRD;
				end
			end
			// squared distance, each axis in an SQ then an ACC state
			ST_SQ: begin
				if (stat.k_end) begin
					state_n = ST_CHK;
				end else begin
					cmd.sq  = 1'b1;
					state_n = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_sum = 1'b1;
				state_n     = ST_SQ;
			end
			ST_CHK: begin
				if (stat.skip) begin
					cmd.j_inc = 1'b1;
					state_n   = ST_JRD;
				end else begin
					cmd.sqrt_go = 1'b1;
					state_n     = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (stat.sqrt_done) begin
					state_n = ST_RAD;
				end
			end
			ST_RAD: begin
				if (stat.in_range) begin
					cmd.rad_ld = 1'b1;
					state_n    = ST_T1;
				end else begin
					cmd.j_inc = 1'b1;
					state_n   = ST_JRD;
				end
			end
			// per-axis force term, then write back the velocity of vertex j
			ST_T1: begin
				if (stat.k_end) begin
					cmd.vj_wr = 1'b1;
					cmd.j_inc = 1'b1;
					state_n   = ST_JRD;
				end else begin
					cmd.t1  = 1'b1;
					state_n = ST_T2;
				end
			end
			ST_T2: begin
				cmd.t2  = 1'b1;
				state_n = ST_T3;
			end
			ST_T3: begin
				cmd.t3  = 1'b1;
				state_n = ST_T4;
			end
			ST_T4: begin
				cmd.t4  = 1'b1;
				state_n = ST_T5;
			end
			ST_T5: begin
				cmd.t5  = 1'b1;
				state_n = ST_T1;
			end
			// move vertex i once its pairs are done, unless it is fixed
			ST_UPD: begin
				cmd.upd_wr = !stat.fix_i;
				cmd.i_inc  = 1'b1;
				state_n    = ST_IRD;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_done = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule
